/* rtl/rcba_pkg.sv */
// Shared types and constants of the reference-counted busy aggregator.
package rcba_pkg;

  localparam int unsigned ActionWidth     = 3;
  localparam int unsigned MaskWidth       = 32;
  localparam int unsigned NumSourcesDef   = 32;
  localparam int unsigned CountWidthDef   = 16;

  typedef enum logic [ActionWidth-1:0] {
    ActCountSet   = 3'd0,
    ActCountClear = 3'd1,
    ActDirectSet  = 3'd2,
    ActDirectClr  = 3'd3,
    ActRead       = 3'd4
  } action_e;

  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic [MaskWidth-1:0]   source_mask;
  } req_t;

  typedef struct packed {
    logic busy_res;
    logic busy_toggled;
    logic changed_since_read;
  } rsp_t;

  typedef struct packed {
    logic en;
    logic count_set;
    logic count_clear;
    logic direct_set;
    logic direct_clear;
    logic modify;
    logic read;
  } cmd_t;

endpackage

/* rtl/rcba_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
interface rcba_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/rcba_lane.sv */
// One busy source: flag bit and saturating reference count.
module rcba_lane #(
  parameter int unsigned COUNT_WIDTH = rcba_pkg::CountWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rcba_pkg::cmd_t cmd_i,
  input  logic          sel_i,
  output logic          flag_d_o
);
  import rcba_pkg::*;

  logic                   flag_q, flag_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  always_comb begin
    flag_d  = flag_q;
    count_d = count_q;
    if (cmd_i.en && sel_i) begin
      if (cmd_i.count_set) begin
        flag_d = 1'b1;
        if (count_q != {COUNT_WIDTH{1'b1}}) begin
          count_d = count_q + 1'b1;
        end
      end else if (cmd_i.count_clear) begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        if (count_d == '0) begin
          flag_d = 1'b0;
        end
      end else if (cmd_i.direct_set) begin
        flag_d = 1'b1;
      end else if (cmd_i.direct_clear) begin
        flag_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= 1'b0;
      count_q <= '0;
    end else begin
      flag_q  <= flag_d;
      count_q <= count_d;
    end
  end

  assign flag_d_o = flag_d;

endmodule

/* rtl/rcba_merge.sv */
// Merge of lane flags: aggregate busy, notify and read snapshots, result register.
module rcba_merge #(
  parameter int unsigned NUM_SOURCES = rcba_pkg::NumSourcesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rcba_pkg::cmd_t         cmd_i,
  input  logic [NUM_SOURCES-1:0] flags_d_i,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output rcba_pkg::rsp_t         rsp_o
);
  import rcba_pkg::*;

  logic notified_q, notified_d;
  logic read_q, read_d;
  logic valid_q, valid_d;
  rsp_t rsp_q, rsp_d;
  logic busy;

  always_comb begin
    busy                   = |flags_d_i;
    rsp_d.busy_res           = busy;
    rsp_d.busy_toggled       = cmd_i.modify && (busy != notified_q);
    rsp_d.changed_since_read = busy != read_q;
    notified_d = notified_q;
    read_d     = read_q;
    valid_d    = valid_q && !rsp_ready_i;
    if (cmd_i.en) begin
      valid_d = 1'b1;
      if (rsp_d.busy_toggled) begin
        notified_d = ~notified_q;
      end
      if (cmd_i.read) begin
        read_d = busy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notified_q <= 1'b0;
      read_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      notified_q <= notified_d;
      read_q     <= read_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/refcounted_busy_aggregator.sv */
// Top level of the reference-counted busy aggregator.
//
//   channel  dir  payload                                          role
//   req_i    in   action, source_mask                              set/clear/read
//   rsp_o    out  busy_res, busy_toggled, changed_since_read       one per request
//
// One request per cycle while the result is not stalled; its result shows in the result register
// in the cycle after the transfer. The lanes selected by source_mask update their flag and count at
// the same edge, and the merge ORs the next flags into the aggregate. Reset clears all flags,
// counts and snapshots at once. A stalled result holds req_i.ready low until it leaves.
module refcounted_busy_aggregator #(
  parameter int unsigned NUM_SOURCES = rcba_pkg::NumSourcesDef,
  parameter int unsigned COUNT_WIDTH = rcba_pkg::CountWidthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rcba_stream_if.sink   req_i,
  rcba_stream_if.source rsp_o
);
  import rcba_pkg::*;

  cmd_t                   cmd;
  logic [NUM_SOURCES-1:0] flags_d;
  logic                   rsp_valid;

  assign req_i.ready = !rsp_valid || rsp_o.ready;

  always_comb begin
    cmd        = '0;
    cmd.en     = req_i.valid && req_i.ready;
    unique case (req_i.payload.action)
      ActCountSet: begin
        cmd.count_set = 1'b1;
        cmd.modify    = 1'b1;
      end
      ActCountClear: begin
        cmd.count_clear = 1'b1;
        cmd.modify      = 1'b1;
      end
      ActDirectSet: begin
        cmd.direct_set = 1'b1;
        cmd.modify     = 1'b1;
      end
      ActDirectClr: begin
        cmd.direct_clear = 1'b1;
        cmd.modify       = 1'b1;
      end
      ActRead: begin
        cmd.read = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_lane
    logic sel;
    if (i < MaskWidth) begin : g_mapped
      assign sel = req_i.payload.source_mask[i];
    end else begin : g_unmapped
      assign sel = 1'b0;
    end

    rcba_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel),
      .flag_d_o(flags_d[i])
    );
  end

  rcba_merge #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .flags_d_i  (flags_d),
    .rsp_ready_i(rsp_o.ready),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp_o.payload)
  );

  assign rsp_o.valid = rsp_valid;

endmodule

/* rtl/rcba_checker.sv */
// Port-level checks of the busy aggregator, bound to the top level.
module rcba_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input rcba_pkg::req_t req_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input rcba_pkg::rsp_t rsp_i
);
  import rcba_pkg::*;

  logic req_xfer;
  assign req_xfer = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled result changed");

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request stalled while result register empty");

  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> rsp_valid_i)
    else $error("request transfer gave no result");

  a_read_no_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && req_i.action == ActRead |=> !rsp_i.busy_toggled)
    else $error("read reported a toggle");

  a_set_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && req_i.source_mask[0] &&
    (req_i.action == ActDirectSet || req_i.action == ActCountSet) |=> rsp_i.busy_res)
    else $error("set of source zero left busy low");

endmodule

bind refcounted_busy_aggregator rcba_checker u_rcba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .req_i      (req_i.payload),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_i      (rsp_o.payload)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the reference-counted busy aggregator with its own busy predictor.
module testbench;
  import rcba_pkg::*;

  localparam int unsigned NumSrc   = NumSourcesDef;
  localparam int unsigned CntWidth = CountWidthDef;

  localparam logic [ActionWidth-1:0] ActSpareLo  = 3'd5;
  localparam logic [ActionWidth-1:0] ActSpareMid = 3'd6;
  localparam logic [ActionWidth-1:0] ActSpareHi  = 3'd7;

  localparam logic [MaskWidth-1:0] AllSources = '1;
  localparam int unsigned RampBurst = 8;

  logic clk_i;
  logic rst_ni;

  rcba_stream_if #(.payload_t(req_t)) req_if ();
  rcba_stream_if #(.payload_t(rsp_t)) rsp_if ();

  refcounted_busy_aggregator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_t pending_reqs[$];
  rsp_t busy_rsp_q[$];

  logic [NumSrc-1:0]   model_flags;
  logic [CntWidth-1:0] model_counts[NumSrc];
  logic                model_read_busy;
  logic                model_notified_busy;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;

  always #5 clk_i = ~clk_i;

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    model_flags         = '0;
    model_read_busy     = 1'b0;
    model_notified_busy = 1'b0;
    for (int i = 0; i < NumSrc; i++) model_counts[i] = '0;
  end

  function automatic rsp_t predict_busy_step(req_t req);
    logic [NumSrc-1:0] lanes;
    logic              modify;
    rsp_t              res;
    lanes  = req.source_mask[NumSrc-1:0];
    modify = 1'b1;
    case (req.action)
      ActCountSet: begin
        for (int i = 0; i < NumSrc; i++) begin
          if (lanes[i]) begin
            model_flags[i] = 1'b1;
            if (model_counts[i] != '1) model_counts[i] = model_counts[i] + 1'b1;
          end
        end
      end
      ActCountClear: begin
        for (int i = 0; i < NumSrc; i++) begin
          if (lanes[i]) begin
            if (model_counts[i] != '0) model_counts[i] = model_counts[i] - 1'b1;
            if (model_counts[i] == '0) model_flags[i] = 1'b0;
          end
        end
      end
      ActDirectSet: model_flags = model_flags | lanes;
      ActDirectClr: model_flags = model_flags & ~lanes;
      default:      modify = 1'b0;
    endcase
    res.busy_res     = |model_flags;
    res.busy_toggled = modify && (res.busy_res != model_notified_busy);
    if (res.busy_toggled) model_notified_busy = ~model_notified_busy;
    res.changed_since_read = res.busy_res != model_read_busy;
    if (req.action == ActRead) model_read_busy = res.busy_res;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) busy_rsp_q.push_back(predict_busy_step(req_if.payload));
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (busy_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %b", $time, got);
        end else begin
          want = busy_rsp_q.pop_front();
          if (got.busy_res !== want.busy_res) begin
            mismatches++;
            $display("%0t: busy_res expected %b actual %b", $time, want.busy_res, got.busy_res);
          end
          if (got.busy_toggled !== want.busy_toggled) begin
            mismatches++;
            $display("%0t: busy_toggled expected %b actual %b",
                     $time, want.busy_toggled, got.busy_toggled);
          end
          if (got.changed_since_read !== want.changed_since_read) begin
            mismatches++;
            $display("%0t: changed_since_read expected %b actual %b",
                     $time, want.changed_since_read, got.changed_since_read);
          end
        end
      end
    end
  end

  task automatic queue_req(logic [ActionWidth-1:0] act, logic [MaskWidth-1:0] mask);
    req_t req;
    req.action      = act;
    req.source_mask = mask;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [MaskWidth-1:0] pick_mask(logic [ActionWidth-1:0] act);
    int unsigned roll;
    roll = $urandom_range(99);
    if (act == ActDirectClr && roll < 35) return AllSources;
    if (roll < 40) return $urandom_range(255) << ($urandom_range(3) * 8);
    if (roll < 60) return 32'd1 << $urandom_range(MaskWidth - 1);
    if (roll < 75) return $urandom;
    if (roll < 80) return AllSources;
    if (roll < 85) return '0;
    return $urandom & $urandom & $urandom;
  endfunction

  function automatic logic [ActionWidth-1:0] pick_action();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return ActCountSet;
    if (roll < 50) return ActCountClear;
    if (roll < 60) return ActDirectSet;
    if (roll < 70) return ActDirectClr;
    if (roll < 92) return ActRead;
    return ActionWidth'($urandom_range(ActSpareHi, ActSpareLo));
  endfunction

  // Half the draws give balanced set/clear bursts, the rest is noise.
  task automatic queue_random_reqs(int unsigned target);
    int unsigned queued;
    int unsigned depth;
    logic [ActionWidth-1:0] act;
    logic [MaskWidth-1:0]   mask;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(1)) begin
        mask  = ($urandom_range(3) == 0) ? $urandom : ($urandom_range(255) << $urandom_range(24));
        depth = $urandom_range(4, 1);
        for (int k = 0; k < depth; k++) begin
          queue_req(ActCountSet, mask);
          if ($urandom_range(2) == 0) queue_req(ActRead, $urandom);
        end
        for (int k = 0; k < depth; k++) queue_req(ActCountClear, mask);
        queue_req(ActRead, $urandom);
        queued += 2 * depth + 1;
      end else begin
        act = pick_action();
        queue_req(act, pick_mask(act));
        queued++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || busy_rsp_q.size() != 0);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_reqs(n);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_req(ActRead, '0);
    queue_req(ActCountSet, 32'h0000_0001);
    queue_req(ActRead, '0);
    queue_req(ActRead, AllSources);
    queue_req(ActDirectSet, 32'h8000_0000);
    queue_req(ActCountClear, 32'h8000_0001);
    queue_req(ActRead, '0);
    queue_req(ActSpareLo, AllSources);
    queue_req(ActSpareMid, AllSources);
    queue_req(ActSpareHi, '0);
    queue_req(ActDirectSet, AllSources);
    queue_req(ActSpareHi, AllSources);
    queue_req(ActCountClear, AllSources);
    queue_req(ActCountSet, '0);
    queue_req(ActCountSet, AllSources);
    queue_req(ActDirectClr, 32'h5555_5555);
    queue_req(ActRead, '0);
    queue_req(ActDirectClr, AllSources);
    queue_req(ActCountClear, '0);
    queue_req(ActCountClear, AllSources);
    queue_req(ActDirectSet, '0);
    queue_req(ActDirectClr, '0);
    queue_req(ActRead, '0);
    drain();

    // ramp every count up, then walk all of them back to zero with extra clears past it
    for (int k = 0; k < RampBurst; k++) queue_req(ActCountSet, AllSources);
    queue_req(ActRead, '0);
    queue_req(ActDirectClr, AllSources);
    queue_req(ActDirectSet, 32'h0000_ffff);
    for (int k = 0; k < RampBurst + 2; k++) queue_req(ActCountClear, AllSources);
    queue_req(ActRead, '0);
    drain();

    run_phase(0, 0, 390);
    run_phase(61, 0, 390);
    run_phase(0, 61, 390);
    run_phase(32, 32, 390);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && busy_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
